// ===== sv/rbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and codes of the reference counted block pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

    // Action codes carried in the action field of an input transfer.
    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_TOUCH    = 3'd1;
    localparam logic [2:0] ACT_RELEASE  = 3'd2;
    localparam logic [2:0] ACT_CACHE    = 3'd3;
    localparam logic [2:0] ACT_LOOKUP   = 3'd4;
    localparam logic [2:0] ACT_EVICT    = 3'd5;
    localparam logic [2:0] ACT_RESET_IX = 3'd6;
    // The one code with no action behind it; such a transfer is ignored.
    localparam logic [2:0] ACT_UNUSED   = 3'd7;

    // Status codes of a result transfer.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_REFUSED   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic [7:0] REF_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  count;
        logic [5:0]  block_index;
        logic [63:0] content_hash;
    } t_in_item;

    typedef struct packed {
        logic [5:0] result_block;
        logic [2:0] status;
        logic       hit;
        logic [5:0] free_blocks_left;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_TOUCH,
        S_REL,
        S_APPEND,
        S_CACHE,
        S_SCAN,
        S_RSCAN,
        S_HVCLR,
        S_RESP
    } t_state;

endpackage

// ===== sv/rbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_ram
// Generic simple dual port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/refcounted_block_pool_with_prefix_index_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_block_pool_with_prefix_index_core
// Block pool with reference counts, an LRU free queue and a prefix index.
// ----------------------------------------------------------------------------
// Touch reads its block in S_TOUCH and answers from S_RESP; release may add S_APPEND.
// An alloc of n blocks gives n results, one per cycle at most while the output slot is free.
// Lookup and cache scan the hash memory one entry a cycle up to a match; a cache self hit skips it.
// Reset index scans counts, then clears hash valid bits; a block in use refuses it.
// One item is in work at a time; the output register lets the next one enter.
// After reset an init pass fills the count, link and hash valid memories; no input meanwhile.
// ----------------------------------------------------------------------------
module refcounted_block_pool_with_prefix_index_core #(
    parameter int POOL_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rbp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rbp_pkg::t_out_item o_out_data
);

    // Index width addresses a block; link width also holds the "none" code.
    localparam int IW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

    rbp_pkg::t_state r_state, n_state;
    rbp_pkg::t_in_item r_item, n_item;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_free, n_free;
    logic [IW-1:0] r_idx, n_idx;
    logic [5:0]    r_left, n_left;
    logic [5:0]    r_final, n_final;
    logic [LW-1:0] r_aux, n_aux;
    logic [IW-1:0] r_resp_blk, n_resp_blk;
    logic [2:0]    r_resp_st, n_resp_st;
    logic          r_resp_hit, n_resp_hit;
    rbp_pkg::t_out_item r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // Memory ports. All memories share one read address.
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          ref_we, prev_we, next_we, hv_we, hash_we;
    logic [IW-1:0] ref_wa, prev_wa, next_wa, hv_wa, hash_wa;
    logic [7:0]    ref_wd;
    logic [LW-1:0] prev_wd, next_wd;
    logic          hv_wd;
    logic [63:0]   hash_wd;
    logic [7:0]    q_ref;
    logic [LW-1:0] q_prev, q_next;
    logic          q_hv;
    logic [63:0]   q_hash;

    // Decode of the arriving item and of the held item.
    logic          in_fire, slot_free;
    logic          in_b_ok, in_b_zero, alloc_go;
    logic [IW-1:0] in_b, cur_b;
    logic          self_hit, scan_match, scan_end;

    assign o_in_ready = (r_state == rbp_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign in_b       = IW'(i_in_data.block_index);
    assign in_b_ok    = int'(i_in_data.block_index) < POOL_SIZE;
    assign in_b_zero  = (i_in_data.block_index == 6'd0);
    assign alloc_go   = (i_in_data.count != 6'd0) &&
                        !(int'(i_in_data.count) > int'(r_free));
    assign cur_b      = IW'(r_item.block_index);

    assign self_hit   = q_hv && (q_hash == r_item.content_hash);
    // A cache scan skips its own block, whose old hash is being dropped.
    assign scan_match = q_hv && (q_hash == r_item.content_hash) &&
                        !((r_item.action == rbp_pkg::ACT_CACHE) && (r_idx == cur_b));
    assign scan_end   = scan_match || (r_idx == LAST_IDX);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbp_pkg::S_INIT: begin
                if (r_idx == LAST_IDX) begin
                    n_state = rbp_pkg::S_IDLE;
                end
            end
            rbp_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.action)
                        rbp_pkg::ACT_ALLOC: begin
                            n_state = alloc_go ? rbp_pkg::S_ALLOC : rbp_pkg::S_RESP;
                        end
                        rbp_pkg::ACT_LOOKUP:   n_state = rbp_pkg::S_SCAN;
                        rbp_pkg::ACT_RESET_IX: n_state = rbp_pkg::S_RSCAN;
                        rbp_pkg::ACT_TOUCH: begin
                            n_state = (in_b_ok && !in_b_zero) ? rbp_pkg::S_TOUCH
                                                              : rbp_pkg::S_RESP;
                        end
                        rbp_pkg::ACT_RELEASE: begin
                            n_state = (in_b_ok && !in_b_zero) ? rbp_pkg::S_REL
                                                              : rbp_pkg::S_RESP;
                        end
                        rbp_pkg::ACT_CACHE: begin
                            n_state = (in_b_ok && !in_b_zero) ? rbp_pkg::S_CACHE
                                                              : rbp_pkg::S_RESP;
                        end
                        default:               n_state = rbp_pkg::S_RESP;
                    endcase
                end
            end
            rbp_pkg::S_ALLOC: begin
                if (slot_free && (r_left == 6'd1)) begin
                    n_state = rbp_pkg::S_IDLE;
                end
            end
            rbp_pkg::S_TOUCH:  n_state = rbp_pkg::S_RESP;
            rbp_pkg::S_REL: begin
                if ((q_ref == 8'd1) && (r_tail != NONE)) begin
                    n_state = rbp_pkg::S_APPEND;
                end else begin
                    n_state = rbp_pkg::S_RESP;
                end
            end
            rbp_pkg::S_APPEND: n_state = rbp_pkg::S_RESP;
            rbp_pkg::S_CACHE:  n_state = self_hit ? rbp_pkg::S_RESP : rbp_pkg::S_SCAN;
            rbp_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = rbp_pkg::S_RESP;
                end
            end
            rbp_pkg::S_RSCAN: begin
                if (q_ref != 8'd0) begin
                    n_state = rbp_pkg::S_RESP;
                end else if (r_idx == LAST_IDX) begin
                    n_state = rbp_pkg::S_HVCLR;
                end
            end
            rbp_pkg::S_HVCLR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = rbp_pkg::S_RESP;
                end
            end
            rbp_pkg::S_RESP: begin
                if (slot_free) begin
                    n_state = rbp_pkg::S_IDLE;
                end
            end
            default: n_state = rbp_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, queue pointers and results.
    always_comb begin
        n_item      = r_item;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_idx       = r_idx;
        n_left      = r_left;
        n_final     = r_final;
        n_aux       = r_aux;
        n_resp_blk  = r_resp_blk;
        n_resp_st   = r_resp_st;
        n_resp_hit  = r_resp_hit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        ref_we  = 1'b0;
        ref_wa  = cur_b;
        ref_wd  = 8'd0;
        prev_we = 1'b0;
        prev_wa = cur_b;
        prev_wd = NONE;
        next_we = 1'b0;
        next_wa = cur_b;
        next_wd = NONE;
        hv_we   = 1'b0;
        hv_wa   = cur_b;
        hv_wd   = 1'b0;
        hash_we = 1'b0;
        hash_wa = cur_b;
        hash_wd = r_item.content_hash;

        case (r_state)
            rbp_pkg::S_INIT: begin
                // Build the reset image: block 0 pinned, the rest chained in order.
                ref_we  = 1'b1;
                ref_wa  = r_idx;
                ref_wd  = (r_idx == '0) ? 8'd1 : 8'd0;
                prev_we = 1'b1;
                prev_wa = r_idx;
                prev_wd = (int'(r_idx) >= 2) ? (LW'(r_idx) - LW'(1)) : NONE;
                next_we = 1'b1;
                next_wa = r_idx;
                next_wd = ((int'(r_idx) >= 1) && (int'(r_idx) + 1 < POOL_SIZE))
                          ? (LW'(r_idx) + LW'(1)) : NONE;
                hv_we   = 1'b1;
                hv_wa   = r_idx;
                n_idx   = r_idx + IW'(1);
            end
            rbp_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_item     = i_in_data;
                    n_resp_blk = '0;
                    n_resp_hit = 1'b0;
                    n_resp_st  = rbp_pkg::ST_IGNORED;
                    case (i_in_data.action)
                        rbp_pkg::ACT_ALLOC: begin
                            if (i_in_data.count == 6'd0) begin
                                n_resp_st = rbp_pkg::ST_IGNORED;
                            end else if (!alloc_go) begin
                                n_resp_st = rbp_pkg::ST_SHORT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[IW-1:0];
                                n_left  = i_in_data.count;
                                n_final = 6'(r_free) - i_in_data.count;
                            end
                        end
                        rbp_pkg::ACT_LOOKUP: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                        end
                        rbp_pkg::ACT_RESET_IX: begin
                            rd_en   = 1'b1;
                            rd_addr = IW'(1);
                            n_idx   = IW'(1);
                        end
                        rbp_pkg::ACT_EVICT: begin
                            if (in_b_ok) begin
                                hv_we     = 1'b1;
                                hv_wa     = in_b;
                                n_resp_st = rbp_pkg::ST_OK;
                            end
                        end
                        rbp_pkg::ACT_TOUCH, rbp_pkg::ACT_RELEASE, rbp_pkg::ACT_CACHE: begin
                            if (in_b_ok && !in_b_zero) begin
                                rd_en   = 1'b1;
                                rd_addr = in_b;
                            end
                        end
                        default: n_resp_st = rbp_pkg::ST_IGNORED;
                    endcase
                end
            end
            rbp_pkg::S_ALLOC: begin
                // Pop the queue head; q_next holds its successor.
                if (slot_free) begin
                    ref_we = 1'b1;
                    ref_wa = r_head[IW-1:0];
                    ref_wd = 8'd1;
                    hv_we  = 1'b1;
                    hv_wa  = r_head[IW-1:0];
                    if (q_next != NONE) begin
                        prev_we = 1'b1;
                        prev_wa = q_next[IW-1:0];
                        prev_wd = NONE;
                    end else begin
                        n_tail = NONE;
                    end
                    n_head = q_next;
                    n_free = r_free - LW'(1);
                    n_out_valid = 1'b1;
                    n_out.result_block     = 6'(r_head[IW-1:0]);
                    n_out.status           = rbp_pkg::ST_OK;
                    n_out.hit              = 1'b0;
                    n_out.free_blocks_left = r_final;
                    n_out.last             = (r_left == 6'd1);
                    n_left = r_left - 6'd1;
                    if (r_left != 6'd1) begin
                        rd_en   = 1'b1;
                        rd_addr = q_next[IW-1:0];
                    end
                end
            end
            rbp_pkg::S_TOUCH: begin
                if (q_ref == rbp_pkg::REF_MAX) begin
                    n_resp_st = rbp_pkg::ST_IGNORED;
                end else begin
                    n_resp_st = rbp_pkg::ST_OK;
                    ref_we = 1'b1;
                    ref_wd = q_ref + 8'd1;
                    if (q_ref == 8'd0) begin
                        // A free block leaves the queue.
                        if (q_prev != NONE) begin
                            next_we = 1'b1;
                            next_wa = q_prev[IW-1:0];
                            next_wd = q_next;
                        end else begin
                            n_head = q_next;
                        end
                        if (q_next != NONE) begin
                            prev_we = 1'b1;
                            prev_wa = q_next[IW-1:0];
                            prev_wd = q_prev;
                        end else begin
                            n_tail = q_prev;
                        end
                        if (r_free != '0) begin
                            n_free = r_free - LW'(1);
                        end
                    end
                end
            end
            rbp_pkg::S_REL: begin
                if (q_ref == 8'd0) begin
                    n_resp_st = rbp_pkg::ST_UNDERFLOW;
                end else begin
                    n_resp_st = rbp_pkg::ST_OK;
                    ref_we = 1'b1;
                    ref_wd = q_ref - 8'd1;
                    if (q_ref == 8'd1) begin
                        // Last reference gone: append at the tail.
                        prev_we = 1'b1;
                        prev_wd = r_tail;
                        next_we = 1'b1;
                        next_wd = NONE;
                        n_tail  = LW'(cur_b);
                        n_free  = r_free + LW'(1);
                        n_aux   = r_tail;
                        if (r_tail == NONE) begin
                            n_head = LW'(cur_b);
                        end
                    end
                end
            end
            rbp_pkg::S_APPEND: begin
                next_we = 1'b1;
                next_wa = r_aux[IW-1:0];
                next_wd = LW'(cur_b);
            end
            rbp_pkg::S_CACHE: begin
                n_resp_st = rbp_pkg::ST_OK;
                if (!self_hit) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_idx   = '0;
                end
            end
            rbp_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_resp_st = rbp_pkg::ST_OK;
                    if (r_item.action == rbp_pkg::ACT_CACHE) begin
                        // If another block owns the hash, only drop ours; else store the new hash.
                        hv_we   = 1'b1;
                        hv_wd   = !scan_match;
                        hash_we = !scan_match;
                    end else begin
                        n_resp_hit = scan_match;
                        n_resp_blk = scan_match ? r_idx : '0;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IW'(1);
                    n_idx   = r_idx + IW'(1);
                end
            end
            rbp_pkg::S_RSCAN: begin
                if (q_ref != 8'd0) begin
                    n_resp_st = rbp_pkg::ST_REFUSED;
                end else if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IW'(1);
                    n_idx   = r_idx + IW'(1);
                end
            end
            rbp_pkg::S_HVCLR: begin
                hv_we     = 1'b1;
                hv_wa     = r_idx;
                n_idx     = r_idx + IW'(1);
                n_resp_st = rbp_pkg::ST_OK;
            end
            rbp_pkg::S_RESP: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out.result_block     = 6'(r_resp_blk);
                    n_out.status           = r_resp_st;
                    n_out.hit              = r_resp_hit;
                    n_out.free_blocks_left = 6'(r_free);
                    n_out.last             = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbp_pkg::S_INIT;
            r_idx       <= '0;
            r_head      <= LW'(1);
            r_tail      <= LW'(POOL_SIZE - 1);
            r_free      <= LW'(POOL_SIZE - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_left     <= n_left;
        r_final    <= n_final;
        r_aux      <= n_aux;
        r_resp_blk <= n_resp_blk;
        r_resp_st  <= n_resp_st;
        r_resp_hit <= n_resp_hit;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    rbp_ram #(.WIDTH(8), .DEPTH(POOL_SIZE)) u_ref_mem (
        .i_clk(i_clk), .i_wr_en(ref_we), .i_wr_addr(ref_wa), .i_wr_data(ref_wd),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(q_ref)
    );

    rbp_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_prev_mem (
        .i_clk(i_clk), .i_wr_en(prev_we), .i_wr_addr(prev_wa), .i_wr_data(prev_wd),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(q_prev)
    );

    rbp_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_next_mem (
        .i_clk(i_clk), .i_wr_en(next_we), .i_wr_addr(next_wa), .i_wr_data(next_wd),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(q_next)
    );

    rbp_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_hv_mem (
        .i_clk(i_clk), .i_wr_en(hv_we), .i_wr_addr(hv_wa), .i_wr_data(hv_wd),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(q_hv)
    );

    rbp_ram #(.WIDTH(64), .DEPTH(POOL_SIZE)) u_hash_mem (
        .i_clk(i_clk), .i_wr_en(hash_we), .i_wr_addr(hash_wa), .i_wr_data(hash_wd),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(q_hash)
    );

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= LW'(POOL_SIZE - 1))
        else $error("free total exceeds pool size");

    a_queue_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) == (r_tail == NONE))
        else $error("queue head and tail disagree on empty queue");

    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbp_pkg::S_ALLOC) |-> (r_head != NONE))
        else $error("alloc running on an empty queue");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("second item taken while one is in work");
`endif

endmodule
